// ----- design/sbe_pkg.sv -----
// ---------------------------------------------------------------------------
// sbe_pkg: shared types and constants of the signature block extractor
// Marker strings, end-marker match candidate table and control encodings.
// ---------------------------------------------------------------------------
package sbe_pkg;

  localparam int BEGIN_LEN = 29;
  localparam int END_LEN   = 27;

  // hold window memory: power-of-two depth so the ring pointers wrap freely
  localparam int WIN_DEPTH = 32;
  localparam int WIN_AW    = 5;
  localparam int CNT_W     = 5;

  localparam logic [15:0] UNIT_CR    = 16'd13;
  localparam logic [15:0] UNIT_LF    = 16'd10;
  localparam logic [15:0] UNIT_HASH  = 16'd35;
  localparam logic [15:0] UNIT_SPACE = 16'd32;
  localparam logic [15:0] UNIT_NUL   = 16'd0;

  localparam logic [8*BEGIN_LEN-1:0] BEGIN_STR = "# SIG # Begin signature block";
  localparam logic [8*END_LEN-1:0]   END_STR   = "# SIG # End signature block";

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_BLOCK,
    PH_DONE,
    PH_ENDED
  } phase_t;

  typedef enum logic [1:0] {
    LF_SKIP,
    LF_HASH,
    LF_COPY
  } line_filter_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EMIT,
    ST_REPORT
  } ctrl_state_t;

  // row k, bit j: a match of length j may follow a match of length k plus one unit
  typedef logic [END_LEN-1:0][END_LEN:0] end_cand_t;

  function automatic logic [7:0] end_char(int i);
    return END_STR[8*(END_LEN-1-i) +: 8];
  endfunction

  function automatic logic [7:0] begin_char(logic [4:0] idx);
    return BEGIN_STR[8*(BEGIN_LEN-1-int'(idx)) +: 8];
  endfunction

  function automatic end_cand_t build_end_cand();
    end_cand_t t;
    logic      ok;
    t = '0;
    for (int k = 0; k < END_LEN; k++) begin
      for (int j = 1; j <= k + 1; j++) begin
        ok = 1'b1;
        for (int i = 0; i + 1 < j; i++) begin
          if (end_char(i) != end_char(k - j + 1 + i)) begin
            ok = 1'b0;
          end
        end
        t[k][j] = ok;
      end
    end
    return t;
  endfunction

  localparam end_cand_t END_CAND = build_end_cand();

endpackage

// ----- design/signature_block_extractor_top.sv -----
// ---------------------------------------------------------------------------
// signature_block_extractor_top: signature block finder and payload stripper
// Scans UTF-16 script text for the begin and end markers of a signature
// block and streams out the stripped payload plus a final report.
// ---------------------------------------------------------------------------
// An input beat is taken whenever the control sits idle. Units that may
// still open the end marker wait in a 32-entry ring memory with a
// registered read; a beat that rules out r of them drains them through
// that single read port (r is at most 27) before the next beat is taken,
// and the final beat adds a report beat. Payload beats (tuser 0) go out
// before the end marker is confirmed; the consumer drops them when the
// report beat (tuser 1, tlast 1) carries found 0. The memory needs no
// clearing after reset: only entries written earlier are ever read.
module signature_block_extractor_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic        s_tlast,   // last_unit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [15:0] payload_unit, [16] found, [48:17] covered_length
  output logic        m_tuser,   // kind
  output logic        m_tlast    // last_result
);

  localparam logic [sbe_pkg::CNT_W-1:0] CNT_ONE = sbe_pkg::CNT_W'(1);

  sbe_pkg::ctrl_state_t  state, state_next;
  sbe_pkg::phase_t       phase, phase_next;
  sbe_pkg::line_filter_t line_filter, line_filter_next;

  logic [4:0]             begin_matched, begin_matched_next;
  logic                   at_line_start, at_line_start_next;
  logic [4:0]             end_matched, end_matched_next;
  logic [LENGTH_BITS-1:0] position, position_next;
  logic                   prev2_is_cr;
  logic [LENGTH_BITS-1:0] candidate_length, candidate_length_next;
  logic [LENGTH_BITS-1:0] covered_len, covered_len_next;

  logic [sbe_pkg::WIN_AW-1:0] head, head_next;
  logic [sbe_pkg::WIN_AW-1:0] rd_ptr;
  logic [sbe_pkg::CNT_W-1:0]  rel_left, rel_count;
  logic                       rep_pending;
  logic                       rep_found;
  logic [LENGTH_BITS-1:0]     rep_len;

  logic [16:0] win_mem [sbe_pkg::WIN_DEPTH];
  logic [16:0] rd_data;
  logic        mem_we;
  logic [16:0] wr_data;

  logic        out_kind, out_found, out_last;
  logic [15:0] out_unit;
  logic [31:0] out_len;

  logic        accept;
  logic        out_free;
  logic        load_pay, load_rep, emit_step;

  logic [15:0] c;
  logic        keep;
  logic [sbe_pkg::END_LEN-1:0] eq;
  logic [sbe_pkg::END_LEN:0]   cand;
  logic [4:0]  nk;

  assign c        = s_tdata;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------- step logic
  always_comb begin
    for (int i = 0; i < sbe_pkg::END_LEN; i++) begin
      eq[i] = (c == {8'h00, sbe_pkg::end_char(i)});
    end
    cand = sbe_pkg::END_CAND[end_matched];
    // longest marker prefix that still ends at this unit
    nk = 5'd0;
    for (int j = 1; j <= sbe_pkg::END_LEN; j++) begin
      if (cand[j] && eq[j-1]) begin
        nk = 5'(j);
      end
    end
  end

  always_comb begin
    phase_next            = phase;
    begin_matched_next    = begin_matched;
    at_line_start_next    = at_line_start;
    end_matched_next      = end_matched;
    line_filter_next      = line_filter;
    candidate_length_next = candidate_length;
    covered_len_next      = covered_len;
    head_next             = head;
    rel_count             = '0;
    keep                  = 1'b0;
    mem_we                = 1'b0;

    if ((phase == sbe_pkg::PH_SEARCH || phase == sbe_pkg::PH_BLOCK) &&
        c == sbe_pkg::UNIT_NUL) begin
      phase_next       = sbe_pkg::PH_ENDED;
      end_matched_next = 5'd0;
    end else if (phase == sbe_pkg::PH_SEARCH) begin
      if (c == sbe_pkg::UNIT_LF) begin
        candidate_length_next = position - LENGTH_BITS'(prev2_is_cr && position != '0);
        begin_matched_next    = 5'd0;
        at_line_start_next    = 1'b1;
      end else if (at_line_start &&
                   c == {8'h00, sbe_pkg::begin_char(begin_matched)}) begin
        begin_matched_next = begin_matched + 5'd1;
        if (begin_matched == 5'(sbe_pkg::BEGIN_LEN - 1)) begin
          covered_len_next   = candidate_length;
          phase_next         = sbe_pkg::PH_BLOCK;
          begin_matched_next = 5'd0;
          at_line_start_next = 1'b0;
          end_matched_next   = 5'd0;
          line_filter_next   = sbe_pkg::LF_SKIP;
        end
      end else begin
        at_line_start_next = 1'b0;
      end
    end else if (phase == sbe_pkg::PH_BLOCK) begin
      if (c == sbe_pkg::UNIT_CR || c == sbe_pkg::UNIT_LF) begin
        line_filter_next = sbe_pkg::LF_SKIP;
      end else if (line_filter == sbe_pkg::LF_SKIP && c == sbe_pkg::UNIT_HASH) begin
        line_filter_next = sbe_pkg::LF_HASH;
      end else if (line_filter != sbe_pkg::LF_COPY && c == sbe_pkg::UNIT_SPACE) begin
        line_filter_next = sbe_pkg::LF_COPY;
      end else begin
        keep             = 1'b1;
        line_filter_next = sbe_pkg::LF_COPY;
      end
      mem_we = 1'b1;
      if (nk == 5'(sbe_pkg::END_LEN)) begin
        phase_next       = sbe_pkg::PH_DONE;
        end_matched_next = 5'd0;
      end else begin
        rel_count        = end_matched + 5'd1 - nk;
        head_next        = head + rel_count;
        end_matched_next = nk;
      end
    end

    position_next = (position != '1) ? position + LENGTH_BITS'(1) : position;
  end

  assign wr_data = {keep, c};

  // ---------------------------------------------------------------- hold window
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      win_mem[head + end_matched] <= wr_data;
    end
    if (state == sbe_pkg::ST_RD) begin
      rd_data <= win_mem[rd_ptr];
    end
  end

  // ---------------------------------------------------------------- control fsm
  always_comb begin
    state_next = state;
    case (state)
      sbe_pkg::ST_IDLE: begin
        if (accept) begin
          if (rel_count != '0) begin
            state_next = sbe_pkg::ST_RD;
          end else if (s_tlast) begin
            state_next = sbe_pkg::ST_REPORT;
          end
        end
      end
      sbe_pkg::ST_RD: begin
        state_next = sbe_pkg::ST_EMIT;
      end
      sbe_pkg::ST_EMIT: begin
        if (emit_step) begin
          if (rel_left == CNT_ONE) begin
            state_next = rep_pending ? sbe_pkg::ST_REPORT : sbe_pkg::ST_IDLE;
          end else begin
            state_next = sbe_pkg::ST_RD;
          end
        end
      end
      sbe_pkg::ST_REPORT: begin
        if (out_free) begin
          state_next = sbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    emit_step = 1'b0;
    load_pay  = 1'b0;
    load_rep  = 1'b0;
    case (state)
      sbe_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      sbe_pkg::ST_EMIT: begin
        // dropped units pass at once, kept ones wait for a free output slot
        emit_step = !rd_data[16] || out_free;
        load_pay  = rd_data[16] && out_free;
      end
      sbe_pkg::ST_REPORT: begin
        load_rep = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- state regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= sbe_pkg::ST_IDLE;
      phase            <= sbe_pkg::PH_SEARCH;
      begin_matched    <= 5'd0;
      at_line_start    <= 1'b1;
      end_matched      <= 5'd0;
      line_filter      <= sbe_pkg::LF_SKIP;
      position         <= '0;
      prev2_is_cr      <= 1'b0;
      candidate_length <= '0;
      covered_len      <= '0;
      head             <= '0;
      rd_ptr           <= '0;
      rel_left         <= '0;
      rep_pending      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rd_ptr      <= head;
        rel_left    <= rel_count;
        rep_pending <= s_tlast;
        if (s_tlast) begin
          // text over: back to the state after reset
          phase            <= sbe_pkg::PH_SEARCH;
          begin_matched    <= 5'd0;
          at_line_start    <= 1'b1;
          end_matched      <= 5'd0;
          line_filter      <= sbe_pkg::LF_SKIP;
          position         <= '0;
          prev2_is_cr      <= 1'b0;
          candidate_length <= '0;
          covered_len      <= '0;
        end else begin
          phase            <= phase_next;
          begin_matched    <= begin_matched_next;
          at_line_start    <= at_line_start_next;
          end_matched      <= end_matched_next;
          line_filter      <= line_filter_next;
          position         <= position_next;
          prev2_is_cr      <= (c == sbe_pkg::UNIT_CR);
          candidate_length <= candidate_length_next;
          covered_len      <= covered_len_next;
        end
        head <= head_next;
      end else if (emit_step) begin
        rd_ptr   <= rd_ptr + sbe_pkg::WIN_AW'(1);
        rel_left <= rel_left - CNT_ONE;
      end else if (load_rep) begin
        rep_pending <= 1'b0;
      end
    end
  end

  // report contents, taken with the final beat
  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      rep_found <= (phase_next == sbe_pkg::PH_DONE);
      rep_len   <= (phase_next == sbe_pkg::PH_DONE) ? covered_len_next : '0;
    end
  end

  // ---------------------------------------------------------------- output reg
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_pay || load_rep) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pay) begin
      out_kind  <= 1'b0;
      out_unit  <= rd_data[15:0];
      out_found <= 1'b0;
      out_len   <= '0;
      out_last  <= 1'b0;
    end else if (load_rep) begin
      out_kind  <= 1'b1;
      out_unit  <= '0;
      out_found <= rep_found;
      out_len   <= 32'(rep_len);
      out_last  <= 1'b1;
    end
  end

  assign m_tdata = {7'd0, out_len, out_found, out_unit};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule
